// ----- hdl/go_to_goal_p_controller_top_defines.svh -----
// ----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_P_CONTROLLER_TOP_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GGPC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GGPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ggpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Widths, fixed-point constants, sequencer states, codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ggpc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam int POS_W     = 16;
    localparam int HEAD_W    = 15;
    localparam int TOL_W     = 15;
    localparam int GAIN_W    = 12;
    localparam int LIN_W     = 16;
    localparam int ANG_W     = 18;
    localparam int DIFF_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // CORDIC working widths: vector components and Q.28 angle accumulator.
    localparam int WORK_SHIFT = 8;
    localparam int XY_W       = 28;
    localparam int Z_W        = 32;
    localparam int BRG_W      = 16;
    localparam int MULB_W     = 17;
    localparam int PROD_W     = XY_W + MULB_W;
    localparam int DIST_W     = 18;
    localparam int DIST_SHIFT = 16 + WORK_SHIFT;
    localparam int BRG_SHIFT  = 16;
    localparam int ANG_SHIFT  = 9;
    localparam int KINV_Q16   = 39797;

    localparam logic signed [Z_W-1:0] HALF_PI_Q28 = Z_W'(421657429);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ITER,
        ST_DIST,
        ST_GAIN,
        ST_DECIDE,
        ST_EMIT
    } ggpc_state_t;

    typedef enum logic [1:0] {
        STAT_NONE,
        STAT_DRIVE,
        STAT_STOP,
        STAT_REACHED
    } ggpc_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE,
        CFG_GAIN,
        CFG_X_MIN,
        CFG_X_MAX,
        CFG_Y_MIN,
        CFG_Y_MAX
    } ggpc_cfg_idx_t;

    typedef struct packed {
        logic init;
        logic step;
    } ggpc_cordic_ctrl_t;

    // arctan(2^-i) in Q.28
    function automatic logic signed [Z_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    atan_q28 = Z_W'(210828714);
            5'd1:    atan_q28 = Z_W'(124459457);
            5'd2:    atan_q28 = Z_W'(65760959);
            5'd3:    atan_q28 = Z_W'(33381290);
            5'd4:    atan_q28 = Z_W'(16755422);
            5'd5:    atan_q28 = Z_W'(8385879);
            5'd6:    atan_q28 = Z_W'(4193963);
            5'd7:    atan_q28 = Z_W'(2097109);
            5'd8:    atan_q28 = Z_W'(1048571);
            5'd9:    atan_q28 = Z_W'(524287);
            5'd10:   atan_q28 = Z_W'(262144);
            5'd11:   atan_q28 = Z_W'(131072);
            5'd12:   atan_q28 = Z_W'(65536);
            5'd13:   atan_q28 = Z_W'(32768);
            5'd14:   atan_q28 = Z_W'(16384);
            5'd15:   atan_q28 = Z_W'(8192);
            5'd16:   atan_q28 = Z_W'(4096);
            5'd17:   atan_q28 = Z_W'(2048);
            5'd18:   atan_q28 = Z_W'(1024);
            5'd19:   atan_q28 = Z_W'(512);
            5'd20:   atan_q28 = Z_W'(256);
            5'd21:   atan_q28 = Z_W'(128);
            5'd22:   atan_q28 = Z_W'(64);
            5'd23:   atan_q28 = Z_W'(32);
            default: atan_q28 = '0;
        endcase
    endfunction

    // Lower bound first, then upper, so the upper bound wins on an inverted box.
    function automatic logic signed [POS_W-1:0] clamp_axis(
        input logic signed [POS_W-1:0] v,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi
    );
        logic signed [POS_W-1:0] r;
        r = v;
        if (r <= lo) r = lo;
        if (r >= hi) r = hi;
        return r;
    endfunction

endpackage

// ----- hdl/ggpc_cordic.sv -----
// ----------------------------------------------------------------------------
// Go-to-goal controller vectoring CORDIC
// One shift-add rotation per cycle; gives the scaled magnitude and the angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ggpc_cordic
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int ITW = $clog2(CORDIC_STEPS)
) (
    input  logic                     aclk,
    input  ggpc_cordic_ctrl_t        ctrl,
    input  logic [ITW-1:0]           step_idx,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic signed [XY_W-1:0]   x_out,
    output logic signed [Z_W-1:0]    z_out
);

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [XY_W-1:0] dx_w, dy_w, xs, ys;
    logic signed [Z_W-1:0]  atan_v;

    always_comb begin
        dx_w   = XY_W'(dx) <<< WORK_SHIFT;
        dy_w   = XY_W'(dy) <<< WORK_SHIFT;
        xs     = x_reg >>> step_idx;
        ys     = y_reg >>> step_idx;
        atan_v = atan_q28(ATAN_IDX_W'(step_idx));
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctrl.init) begin
            // Vectors in the left half-plane are first turned by a quarter turn.
            if (dx_w < 0) begin
                if (dy_w >= 0) begin
                    x_next = dy_w;
                    y_next = -dx_w;
                    z_next = HALF_PI_Q28;
                end else begin
                    x_next = -dy_w;
                    y_next = dx_w;
                    z_next = -HALF_PI_Q28;
                end
            end else begin
                x_next = dx_w;
                y_next = dy_w;
                z_next = '0;
            end
        end else if (ctrl.step) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_v;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

// ----- hdl/go_to_goal_p_controller_top.sv -----
// ----------------------------------------------------------------------------
// Go-to-goal proportional controller, top level
// Destination items and idle pose items pass from load straight to emit.
// Running pose items pass through the CORDIC (one rotation per cycle), distance, gain and decide
// steps, with one multiplier shared by distance and gain; a new item is taken only after emit.
// Synchronous active-low reset restores register defaults and clears goal and run flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "go_to_goal_p_controller_top_defines.svh"

module go_to_goal_p_controller_top
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x[15:0], pos_y[31:16], heading[46:32], dest_x[62:47], dest_y[78:63],
    // dest_move[79]
    input  logic [79:0]           s_tdata,
    // mode[0]
    input  logic                  s_tuser,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // linear_speed[15:0], angular_speed[33:16], zero[39:34]
    output logic [39:0]           m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser
);

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_STEPS - 1);
    localparam logic signed [PROD_W-1:0] ANG_HI = PROD_W'(131071);
    localparam logic signed [PROD_W-1:0] ANG_LO = PROD_W'(-131072);
    localparam logic signed [PROD_W-1:0] DIST_HALF = PROD_W'(1) <<< (DIST_SHIFT - 1);

    ggpc_state_t state_reg, state_next;
    logic [ITW-1:0] iter_reg, iter_next;

    logic [TOL_W-1:0]        tol_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic signed [POS_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;

    logic signed [POS_W-1:0] target_x_reg, target_x_next;
    logic signed [POS_W-1:0] target_y_reg, target_y_next;
    logic                    running_reg, running_next;

    logic                     mode_reg;
    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg, dest_x_reg, dest_y_reg;
    logic signed [HEAD_W-1:0] heading_reg;
    logic                     dest_move_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [BRG_W-1:0]  bearing_reg, bearing_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;

    ggpc_status_t            res_status_reg, res_status_next;
    logic [LIN_W-1:0]        res_lin_reg, res_lin_next;
    logic signed [ANG_W-1:0] res_ang_reg, res_ang_next;

    logic                    m_tvalid_reg;
    ggpc_status_t            m_status_reg;
    logic [LIN_W-1:0]        m_lin_reg;
    logic signed [ANG_W-1:0] m_ang_reg;

    ggpc_cordic_ctrl_t        cordic_ctrl;
    logic                     emit_fire;
    logic signed [DIFF_W-1:0] dx, dy, diff;
    logic signed [XY_W-1:0]   cordic_x, mul_a;
    logic signed [Z_W-1:0]    cordic_z, z_adj, z_sum;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] ang_adj, ang_full, dist_sum;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD:   state_next = (!mode_reg && running_reg) ? ST_ITER : ST_EMIT;
            ST_ITER:   if (iter_reg == ITER_LAST) state_next = ST_DIST;
            ST_DIST:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_EMIT;
            ST_EMIT:   if (emit_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        cordic_ctrl.init = (state_reg == ST_LOAD) && !mode_reg && running_reg;
        cordic_ctrl.step = (state_reg == ST_ITER);
        emit_fire        = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
        iter_next        = (state_reg == ST_ITER) ? iter_reg + ITW'(1) : '0;
    end

    // ------------------------------------------------------------------
    // CORDIC and the shared multiplier
    // ------------------------------------------------------------------
    assign dx = DIFF_W'(target_x_reg) - DIFF_W'(pos_x_reg);
    assign dy = DIFF_W'(target_y_reg) - DIFF_W'(pos_y_reg);

    ggpc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .ctrl    (cordic_ctrl),
        .step_idx(iter_reg),
        .dx      (dx),
        .dy      (dy),
        .x_out   (cordic_x),
        .z_out   (cordic_z)
    );

    always_comb begin
        diff = DIFF_W'(bearing_reg) - DIFF_W'(heading_reg);
        if (state_reg == ST_GAIN) begin
            mul_a = XY_W'(diff);
            mul_b = $signed({{(MULB_W - GAIN_W){1'b0}}, gain_reg});
        end else begin
            mul_a = cordic_x;
            mul_b = MULB_W'(KINV_Q16);
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

        // Round to nearest, ties away from zero.
        z_adj        = cordic_z[Z_W-1] ? Z_W'((1 <<< (BRG_SHIFT - 1)) - 1)
                                       : Z_W'(1 <<< (BRG_SHIFT - 1));
        z_sum        = cordic_z + z_adj;
        bearing_next = BRG_W'(z_sum >>> BRG_SHIFT);

        // The magnitude is never negative, so plain half-up rounding applies.
        dist_sum  = prod_reg + DIST_HALF;
        dist_next = dist_sum[DIST_SHIFT +: DIST_W];

        ang_adj  = prod_reg[PROD_W-1] ? PROD_W'((1 <<< (ANG_SHIFT - 1)) - 1)
                                      : PROD_W'(1 <<< (ANG_SHIFT - 1));
        ang_full = (prod_reg + ang_adj) >>> ANG_SHIFT;
    end

    // ------------------------------------------------------------------
    // Goal, run flag and pending result
    // ------------------------------------------------------------------
    always_comb begin
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        running_next    = running_reg;
        res_status_next = res_status_reg;
        res_lin_next    = res_lin_reg;
        res_ang_next    = res_ang_reg;
        case (state_reg)
            ST_LOAD: begin
                res_status_next = STAT_NONE;
                res_lin_next    = '0;
                res_ang_next    = '0;
                if (mode_reg) begin
                    target_x_next = clamp_axis(dest_x_reg, xmin_reg, xmax_reg);
                    target_y_next = clamp_axis(dest_y_reg, ymin_reg, ymax_reg);
                    running_next  = dest_move_reg;
                end else if (!running_reg) begin
                    // Idle pose on or beyond an edge: stop and aim at that edge.
                    if (pos_x_reg <= xmin_reg || pos_x_reg >= xmax_reg ||
                        pos_y_reg <= ymin_reg || pos_y_reg >= ymax_reg) begin
                        res_status_next = STAT_STOP;
                        running_next    = 1'b1;
                        if (pos_x_reg <= xmin_reg) target_x_next = xmin_reg;
                        else if (pos_x_reg >= xmax_reg) target_x_next = xmax_reg;
                        if (pos_y_reg <= ymin_reg) target_y_next = ymin_reg;
                        else if (pos_y_reg >= ymax_reg) target_y_next = ymax_reg;
                    end
                end
            end
            ST_DECIDE: begin
                if (dist_reg > DIST_W'(tol_reg)) begin
                    res_status_next = STAT_DRIVE;
                    res_lin_next    = (dist_reg > DIST_W'(16'hFFFF)) ? 16'hFFFF
                                                                    : dist_reg[LIN_W-1:0];
                    if (ang_full > ANG_HI) res_ang_next = ANG_HI[ANG_W-1:0];
                    else if (ang_full < ANG_LO) res_ang_next = ANG_LO[ANG_W-1:0];
                    else res_ang_next = ang_full[ANG_W-1:0];
                    target_x_next = clamp_axis(target_x_reg, xmin_reg, xmax_reg);
                    target_y_next = clamp_axis(target_y_reg, ymin_reg, ymax_reg);
                end else begin
                    res_status_next = STAT_REACHED;
                    res_lin_next    = '0;
                    res_ang_next    = '0;
                    running_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            tol_reg      <= TOL_W'(205);
            gain_reg     <= GAIN_W'(1280);
            xmin_reg     <= POS_W'(2048);
            xmax_reg     <= POS_W'(20480);
            ymin_reg     <= POS_W'(2048);
            ymax_reg     <= POS_W'(20480);
            target_x_reg <= '0;
            target_y_reg <= '0;
            running_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            running_reg  <= running_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TOLERANCE: tol_reg  <= cfg_data[TOL_W-1:0];
                    CFG_GAIN:      gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_X_MIN:     xmin_reg <= cfg_data;
                    CFG_X_MAX:     xmax_reg <= cfg_data;
                    CFG_Y_MIN:     ymin_reg <= cfg_data;
                    CFG_Y_MAX:     ymax_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (emit_fire) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg      <= s_tuser;
            pos_x_reg     <= s_tdata[15:0];
            pos_y_reg     <= s_tdata[31:16];
            heading_reg   <= s_tdata[46:32];
            dest_x_reg    <= s_tdata[62:47];
            dest_y_reg    <= s_tdata[78:63];
            dest_move_reg <= s_tdata[79];
        end
        if (state_reg == ST_DIST || state_reg == ST_GAIN) prod_reg <= prod_next;
        if (state_reg == ST_DIST) bearing_reg <= bearing_next;
        if (state_reg == ST_GAIN) dist_reg <= dist_next;
        res_status_reg <= res_status_next;
        res_lin_reg    <= res_lin_next;
        res_ang_reg    <= res_ang_next;
        if (emit_fire) begin
            m_status_reg <= res_status_reg;
            m_lin_reg    <= res_lin_reg;
            m_ang_reg    <= res_ang_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {6'b0, m_ang_reg, m_lin_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GGPC_ASSERT_IMPLIES(a_emit_source, $rose(m_tvalid_reg), $past(state_reg) == ST_EMIT,
        "result item raised outside the emit step")
    `GGPC_ASSERT_IMPLIES(a_zero_speeds, m_tvalid_reg && m_status_reg != STAT_DRIVE,
        m_lin_reg == '0 && m_ang_reg == '0, "non-drive result carries a speed")
    `GGPC_ASSERT_IMPLIES(a_run_clear, $fell(running_reg),
        $past(state_reg) == ST_DECIDE || $past(state_reg) == ST_LOAD,
        "run flag cleared outside arrival or destination handling")
    `GGPC_ASSERT_NEXT(a_dest_none, emit_fire && mode_reg, m_status_reg == STAT_NONE,
        "destination item produced a command")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Go-to-goal controller regression testbench
// Streams destination and pose items through the controller and checks every
// command it emits against an in-bench fixed-point model of the controller.
// The box, gain and tolerance are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ggpc_pkg::*;

    localparam int     CORDIC_ITERS     = 16;
    localparam int     ATAN_COUNT       = 24;
    localparam longint INV_GAIN_Q16     = 39797;
    localparam longint QUARTER_TURN_Q28 = 421657429;
    localparam int     RAND_PER_PHASE   = 105;
    localparam int     CYCLE_LIMIT      = 400000;

    localparam longint ATAN_Q28 [0:ATAN_COUNT-1] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    typedef enum logic {
        MODE_POSE = 1'b0,
        MODE_DEST = 1'b1
    } item_mode_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_pattern_t;

    typedef struct packed {
        item_mode_t         mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [14:0] heading;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic               dest_move;
    } ctrl_item_t;

    typedef struct packed {
        ggpc_status_t status;
        logic [15:0]  lin;
        logic [17:0]  ang;
    } cmd_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Model of the controller state and its registers.
    logic [14:0]        tol_q     = 15'd205;
    logic [11:0]        gain_q    = 12'd1280;
    logic signed [15:0] box_x_lo  = 16'sd2048;
    logic signed [15:0] box_x_hi  = 16'sd20480;
    logic signed [15:0] box_y_lo  = 16'sd2048;
    logic signed [15:0] box_y_hi  = 16'sd20480;
    logic signed [15:0] goal_x    = '0;
    logic signed [15:0] goal_y    = '0;
    logic               moving    = 1'b0;

    ctrl_item_t  item_q [$];
    cmd_t        cmd_expect_q [$];
    ctrl_item_t  drv_item;
    bit          item_taken     = 1'b0;
    int          items_queued   = 0;
    int          cmds_checked   = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    rx_pattern_t rx_pattern     = RX_OPEN;
    int          rx_left        = 0;
    int          rx_tick        = 0;

    go_to_goal_p_controller_top #(
        .CORDIC_STEPS (CORDIC_ITERS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint round_away(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (s - 1))) >> s;
        return (v < 0) ? -mag : mag;
    endfunction

    // The upper bound is applied last, so it wins when the box is inverted.
    function automatic void clamp_goal();
        if (goal_x <= box_x_lo) goal_x = box_x_lo;
        if (goal_y <= box_y_lo) goal_y = box_y_lo;
        if (goal_x >= box_x_hi) goal_x = box_x_hi;
        if (goal_y >= box_y_hi) goal_y = box_y_hi;
    endfunction

    function automatic void apply_reg_write(ggpc_cfg_idx_t idx, logic [15:0] v);
        case (idx)
            CFG_TOLERANCE: tol_q    = v[14:0];
            CFG_GAIN:      gain_q   = v[11:0];
            CFG_X_MIN:     box_x_lo = v;
            CFG_X_MAX:     box_x_hi = v;
            CFG_Y_MIN:     box_y_lo = v;
            CFG_Y_MAX:     box_y_hi = v;
            default: ;
        endcase
    endfunction

    function automatic cmd_t predict_command(ctrl_item_t it);
        cmd_t   r;
        longint px, py, hd, x, y, z, t, xs, ys, dist_q, brg, ang;
        int     i;
        r.status = STAT_NONE;
        r.lin    = '0;
        r.ang    = '0;
        px = longint'(it.pos_x);
        py = longint'(it.pos_y);
        hd = longint'(it.heading);
        if (it.mode == MODE_DEST) begin
            goal_x = it.dest_x;
            goal_y = it.dest_y;
            clamp_goal();
            moving = it.dest_move;
        end else if (moving) begin
            x = (longint'(goal_x) - px) * 256;
            y = (longint'(goal_y) - py) * 256;
            z = 0;
            // Vectors in the left half plane are turned a quarter turn first.
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = QUARTER_TURN_Q28;
                end else begin
                    x = -y;
                    y = t;
                    z = -QUARTER_TURN_Q28;
                end
            end
            for (i = 0; i < CORDIC_ITERS && i < ATAN_COUNT; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q28[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q28[i];
                end
            end
            dist_q = round_away(x * INV_GAIN_Q16, 24);
            brg    = round_away(z, 16);
            if (dist_q > longint'(tol_q)) begin
                r.status = STAT_DRIVE;
                r.lin    = (dist_q > 65535) ? 16'hFFFF : 16'(dist_q);
                ang = round_away((brg - hd) * longint'(gain_q), 9);
                if (ang > 131071) ang = 131071;
                if (ang < -131072) ang = -131072;
                r.ang = 18'(ang);
                clamp_goal();
            end else begin
                r.status = STAT_REACHED;
                moving   = 1'b0;
            end
        end else if (px <= longint'(box_x_lo) || px >= longint'(box_x_hi) ||
                     py <= longint'(box_y_lo) || py >= longint'(box_y_hi)) begin
            r.status = STAT_STOP;
            if (px <= longint'(box_x_lo)) goal_x = box_x_lo;
            else if (px >= longint'(box_x_hi)) goal_x = box_x_hi;
            if (py <= longint'(box_y_lo)) goal_y = box_y_lo;
            else if (py >= longint'(box_y_hi)) goal_y = box_y_hi;
            moving = 1'b1;
        end
        return r;
    endfunction

    // Sender: bursts of items separated by random gaps, some bursts back to back.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || item_taken)) begin
            item_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (item_q.size() > 0) begin
                drv_item = item_q.pop_front();
                s_tdata  <= {drv_item.dest_move, drv_item.dest_y, drv_item.dest_x,
                             drv_item.heading, drv_item.pos_y, drv_item.pos_x};
                s_tuser  <= drv_item.mode;
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the back-pressure pattern is re-drawn at random each time its run ends.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_left    = $urandom_range(40, 200);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_pattern)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_tready <= ((rx_tick % 6) < 2);
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : monitor
        cmd_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cmd_expect_q.size() == 0) begin
                    $display("%0t: unexpected command: expected none, actual status %0d lin %0d ang %0d",
                             $time, m_tuser, m_tdata[15:0], $signed(m_tdata[33:16]));
                    mismatch_count++;
                end else begin
                    want = cmd_expect_q.pop_front();
                    cmds_checked++;
                    if (m_tuser !== want.status || m_tdata[15:0] !== want.lin ||
                        m_tdata[33:16] !== want.ang) begin
                        $display("%0t: command mismatch: expected status %0d lin %0d ang %0d",
                                 $time, want.status, want.lin, $signed(want.ang));
                        $display("%0t:                   actual   status %0d lin %0d ang %0d",
                                 $time, m_tuser, m_tdata[15:0], $signed(m_tdata[33:16]));
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                cmd_expect_q.push_back(predict_command(drv_item));
                item_taken = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("go_to_goal_p_controller_top regression: fail");
            $finish;
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int sat16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Inside the span, exactly on either edge, or anywhere at all.
    function automatic int pick_coord(int lo, int hi, int edge_lo, int edge_hi);
        case ($urandom_range(0, 3))
            0:       return rand_between(lo, hi);
            1:       return edge_lo;
            2:       return edge_hi;
            default: return rand_between(-32768, 32767);
        endcase
    endfunction

    task automatic queue_item(ctrl_item_t it);
        item_q.push_back(it);
        items_queued++;
    endtask

    task automatic add_pose(int px, int py, int hd);
        ctrl_item_t it;
        it.mode      = MODE_POSE;
        it.pos_x     = 16'(px);
        it.pos_y     = 16'(py);
        it.heading   = 15'(hd);
        it.dest_x    = 16'($urandom);
        it.dest_y    = 16'($urandom);
        it.dest_move = 1'($urandom);
        queue_item(it);
    endtask

    task automatic add_dest(int gx, int gy, bit mv);
        ctrl_item_t it;
        it.mode      = MODE_DEST;
        it.pos_x     = 16'($urandom);
        it.pos_y     = 16'($urandom);
        it.heading   = 15'($urandom);
        it.dest_x    = 16'(gx);
        it.dest_y    = 16'(gy);
        it.dest_move = mv;
        queue_item(it);
    endtask

    task automatic wait_drained();
        while (cmds_checked != items_queued) @(negedge aclk);
    endtask

    task automatic write_reg(ggpc_cfg_idx_t idx, logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg_write(idx, v);
    endtask

    task automatic apply_config(logic [15:0] tol, logic [15:0] gn, logic [15:0] xlo,
                                logic [15:0] xhi, logic [15:0] ylo, logic [15:0] yhi);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_GAIN, gn);
        write_reg(CFG_X_MIN, xlo);
        write_reg(CFG_X_MAX, xhi);
        write_reg(CFG_Y_MIN, ylo);
        write_reg(CFG_Y_MAX, yhi);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly trips: a goal inside the box followed by poses closing in on it,
    // often ending within the tolerance. The rest holds with idle poses inside the
    // box, on its edges or anywhere, plus fully random items.
    task automatic add_random_items(int n);
        int k, j, steps, span, half, gx, gy, xa, xb, ya, yb;
        k = 0;
        while (k < n) begin
            xa = (box_x_lo < box_x_hi) ? int'(box_x_lo) : int'(box_x_hi);
            xb = (box_x_lo < box_x_hi) ? int'(box_x_hi) : int'(box_x_lo);
            ya = (box_y_lo < box_y_hi) ? int'(box_y_lo) : int'(box_y_hi);
            yb = (box_y_lo < box_y_hi) ? int'(box_y_hi) : int'(box_y_lo);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    gx = rand_between(xa, xb);
                    gy = rand_between(ya, yb);
                    add_dest(gx, gy, 1'b1);
                    steps = $urandom_range(2, 8);
                    for (j = 0; j < steps; j++) begin
                        if (j == steps - 1 && $urandom_range(0, 2) != 0) begin
                            half = int'(tol_q) / 2;
                        end else begin
                            half = 16384 >> j;
                        end
                        add_pose(sat16(gx + rand_between(-half, half)),
                                 sat16(gy + rand_between(-half, half)),
                                 rand_between(-16384, 16383));
                    end
                    k += steps + 1;
                end
                12, 13, 14: begin
                    add_dest(rand_between(-32768, 32767), rand_between(-32768, 32767), 1'b0);
                    steps = $urandom_range(1, 4);
                    for (j = 0; j < steps; j++) begin
                        add_pose(pick_coord(xa, xb, int'(box_x_lo), int'(box_x_hi)),
                                 pick_coord(ya, yb, int'(box_y_lo), int'(box_y_hi)),
                                 rand_between(-16384, 16383));
                    end
                    k += steps + 1;
                end
                default: begin
                    if ($urandom_range(0, 1) != 0) begin
                        add_dest(rand_between(-32768, 32767), rand_between(-32768, 32767),
                                 1'($urandom));
                    end else begin
                        add_pose(rand_between(-32768, 32767), rand_between(-32768, 32767),
                                 rand_between(-16384, 16383));
                    end
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        int p, a, b, c, d;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: idle inside, stop on an edge, both quarter-turn
        // paths, zero distance, arrival at and near the tolerance.
        add_pose(8192, 8192, 0);
        add_pose(2048, 8192, 16383);
        add_pose(8192, 8192, -16384);
        add_pose(4096, 0, 0);
        add_pose(2048, 2148, 0);
        add_dest(-32768, 32767, 1'b1);
        add_pose(2048, 0, 0);
        add_pose(10000, 20480, 100);
        add_pose(2048, 20480, 0);
        add_dest(32767, -32768, 1'b0);
        add_pose(20480, 8192, 0);
        add_pose(0, 4096, 0);
        add_pose(20480, 2253, 0);
        add_pose(-32768, 32767, 0);
        add_dest(12000, 12000, 1'b1);
        add_pose(12300, 12000, -16384);
        wait_drained();

        // Widest box, zero tolerance, full gain: both speeds saturate.
        apply_config(16'h0000, 16'h0FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        add_dest(32767, 32767, 1'b1);
        add_pose(-32768, -32768, -16384);
        add_pose(-32768, 32767, 16383);
        add_dest(-32768, -32768, 1'b1);
        add_pose(32767, -32767, 16383);
        add_pose(-32768, -32768, 0);
        add_pose(-32768, 0, 0);
        add_random_items(RAND_PER_PHASE);
        wait_drained();

        // Largest tolerance with no gain.
        apply_config(16'h7FFF, 16'h0000, 16'd2048, 16'd20480, 16'd2048, 16'd20480);
        add_random_items(RAND_PER_PHASE);
        wait_drained();

        // Inverted box on both axes.
        apply_config(16'd400, 16'd2000, 16'd8192, 16'(-8192), 16'd4096, 16'(-4096));
        add_random_items(RAND_PER_PHASE);
        wait_drained();

        for (p = 0; p < 3; p++) begin
            a = rand_between(-32768, 32767);
            b = rand_between(-32768, 32767);
            c = rand_between(-32768, 32767);
            d = rand_between(-32768, 32767);
            apply_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 4095)),
                         16'((a < b) ? a : b), 16'((a < b) ? b : a),
                         16'((c < d) ? c : d), 16'((c < d) ? d : c));
            add_random_items(RAND_PER_PHASE);
            wait_drained();
        end

        // Arbitrary register data, including the unused upper bits.
        apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        add_random_items(RAND_PER_PHASE);
        wait_drained();

        apply_config(16'd205, 16'd1280, 16'd2048, 16'd20480, 16'd2048, 16'd20480);
        add_random_items(RAND_PER_PHASE);
        wait_drained();

        repeat (CORDIC_ITERS + 6) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("go_to_goal_p_controller_top regression: pass");
        end else begin
            $display("go_to_goal_p_controller_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ggpc_pkg.sv
hdl/ggpc_cordic.sv
hdl/go_to_goal_p_controller_top.sv
tb/testbench.sv
